// File: hw/rtl/qte_pkg.sv
// shared constants, types and arctangent table for the quaternion to euler core
// no dependencies
package qte_pkg;

  localparam int unsigned QW = 16;
  localparam int unsigned PW = 32;
  localparam int unsigned TW = 34;
  localparam int unsigned SW = 32;
  localparam int unsigned AW = 31;
  localparam int unsigned NW = 61;
  localparam int unsigned CW = 36;
  localparam int unsigned ZW = 35;
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned DEF_CORDIC_STAGES = 16;
  localparam int unsigned ATAN_LEN = 24;

  localparam logic signed [TW-1:0] ONE_Q30 = TW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] PI_Q30 = ZW'(64'sd3373259426);
  localparam logic signed [NW:0] ONE_Q60 = (NW + 1)'(1) << 60;
  localparam logic signed [17:0] PI_Q13 = 18'sd25736;
  localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;

  typedef struct packed {
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
    logic signed [SW-1:0] t2;
    logic signed [TW-1:0] t3;
    logic signed [TW-1:0] t4;
  } terms_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0: r = ZW'(843314857);
      1: r = ZW'(497837829);
      2: r = ZW'(263043837);
      3: r = ZW'(133525159);
      4: r = ZW'(67021687);
      5: r = ZW'(33543516);
      6: r = ZW'(16775851);
      7: r = ZW'(8388437);
      8: r = ZW'(4194283);
      9: r = ZW'(2097149);
      default: r = ZW'(1) << (30 - idx);
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/qte_isqrt.sv
// pipelined floor square root, one result bit per stage
// uses qte_pkg
module qte_isqrt (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [qte_pkg::NW-1:0]  n_i,
  output logic [qte_pkg::AW-1:0]  root_o
);
  import qte_pkg::*;

  localparam int unsigned RW = 62;

  logic [NW-1:0] n_q [0:SQRT_STEPS];
  logic [RW-1:0] r_q [0:SQRT_STEPS];

  assign n_q[0] = n_i;
  assign r_q[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [RW-1:0] Bit = RW'(1) << (60 - 2 * k);
    logic [RW:0] trial;
    assign trial = {1'b0, r_q[k]} + {1'b0, Bit};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({{(RW + 1 - NW){1'b0}}, n_q[k]} >= trial) begin
          n_q[k+1] <= n_q[k] - trial[NW-1:0];
          r_q[k+1] <= (r_q[k] >> 1) + Bit;
        end else begin
          n_q[k+1] <= n_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
      end
    end
  end

  assign root_o = r_q[SQRT_STEPS][AW-1:0];

endmodule

// File: hw/rtl/qte_cordic.sv
// pipelined vectoring cordic giving atan2(y, x) in q30
// uses qte_pkg
module qte_cordic #(
  parameter int unsigned CORDIC_STAGES = qte_pkg::DEF_CORDIC_STAGES
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [qte_pkg::CW-1:0]  y_i,
  input  logic signed [qte_pkg::CW-1:0]  x_i,
  output logic signed [qte_pkg::ZW-1:0]  z_o
);
  import qte_pkg::*;

  logic signed [CW-1:0] x_q [0:CORDIC_STAGES];
  logic signed [CW-1:0] y_q [0:CORDIC_STAGES];
  logic signed [ZW-1:0] z_q [0:CORDIC_STAGES];
  logic                 zero_q [0:CORDIC_STAGES];

  // quadrant fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= (y_i >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    localparam logic signed [ZW-1:0] Atan = atan_q30(i);
    logic signed [CW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + Atan;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - Atan;
        end
      end
    end
  end

  assign z_o = zero_q[CORDIC_STAGES] ? '0 : z_q[CORDIC_STAGES];

endmodule

// File: hw/rtl/quaternion_to_euler_angles_core.sv
// Quaternion (x, y, z, w, signed Q1.15) to roll, pitch and yaw in radians (roll and yaw
// signed Q3.13, pitch signed Q2.13). Fully pipelined: one beat is taken every clock while
// the output is not stalled; the depth is set by the 31-step square root for the pitch
// cosine and the CORDIC iteration pipeline. A stall on a valid output freezes the whole
// pipeline and is passed straight back to the input.
// uses qte_pkg, qte_isqrt, qte_cordic
module quaternion_to_euler_angles_core #(
  parameter int unsigned CORDIC_STAGES = qte_pkg::DEF_CORDIC_STAGES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [15:0]       quat_x_i,
  input  logic signed [15:0]       quat_y_i,
  input  logic signed [15:0]       quat_z_i,
  input  logic signed [15:0]       quat_w_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [15:0]       roll_angle_o,
  output logic signed [14:0]       pitch_angle_o,
  output logic signed [15:0]       yaw_angle_o
);
  import qte_pkg::*;

  localparam int unsigned LAT = 37 + CORDIC_STAGES;
  localparam int unsigned TD = 34;

  logic en;
  logic vld_q [0:LAT-1];

  assign en = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // products
  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, zz_q, wy_q, zx_q, wz_q, xy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
    end
  end

  // term sums
  terms_t td_q [0:TD-1];
  terms_t terms_d;
  logic signed [TW-1:0] s0, s1, s2, s3, s4;
  always_comb begin
    s0 = TW'(wx_q) + TW'(yz_q);
    s1 = TW'(xx_q) + TW'(yy_q);
    s2 = (TW'(wy_q) - TW'(zx_q)) <<< 1;
    s3 = TW'(wz_q) + TW'(xy_q);
    s4 = TW'(yy_q) + TW'(zz_q);
    terms_d.t0 = s0 <<< 1;
    terms_d.t1 = ONE_Q30 - (s1 <<< 1);
    terms_d.t3 = s3 <<< 1;
    terms_d.t4 = ONE_Q30 - (s4 <<< 1);
    if (s2 > ONE_Q30) terms_d.t2 = SW'(ONE_Q30);
    else if (s2 < -ONE_Q30) terms_d.t2 = SW'(-ONE_Q30);
    else terms_d.t2 = SW'(s2);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      td_q[0] <= terms_d;
      for (int i = 1; i < TD; i++) td_q[i] <= td_q[i-1];
    end
  end

  // pitch cosine operand
  logic [AW-1:0] abs_t2;
  logic [2*AW-1:0] sq_q;
  logic [NW-1:0] n_q;
  logic signed [NW:0] n_d;
  assign abs_t2 = td_q[0].t2[SW-1] ? AW'(-td_q[0].t2) : AW'(td_q[0].t2);
  assign n_d = ONE_Q60 - $signed({1'b0, sq_q[NW-1:0]});

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q <= abs_t2 * abs_t2;
      n_q  <= n_d[NW-1:0];
    end
  end

  logic [AW-1:0] cos_root;
  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (n_q),
    .root_o (cos_root)
  );

  logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;

  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (CW'(td_q[TD-1].t0)),
    .x_i   (CW'(td_q[TD-1].t1)),
    .z_o   (roll_z)
  );

  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (CW'(td_q[TD-1].t2)),
    .x_i   ($signed({{(CW - AW){1'b0}}, cos_root})),
    .z_o   (pitch_z)
  );

  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (CW'(td_q[TD-1].t3)),
    .x_i   (CW'(td_q[TD-1].t4)),
    .z_o   (yaw_z)
  );

  // round to q13 and clamp
  function automatic logic signed [17:0] to_q13(input logic signed [ZW-1:0] z,
                                               input logic signed [17:0] lim);
    logic signed [ZW-1:0] rz;
    logic signed [17:0] r;
    rz = (z + ZW'(65536)) >>> 17;
    r = 18'(rz);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  logic signed [17:0] roll_r, pitch_r, yaw_r;
  assign roll_r  = to_q13(roll_z, PI_Q13);
  assign pitch_r = to_q13(pitch_z, HALF_PI_Q13);
  assign yaw_r   = to_q13(yaw_z, PI_Q13);

  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_r[15:0];
      pitch_q <= pitch_r[14:0];
      yaw_q   <= yaw_r[15:0];
    end
  end

  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;

endmodule

// File: test/quaternion_to_euler_angles_core_tb.sv
// testbench for quaternion_to_euler_angles_core: drives quaternion beats with random
// gaps and output stalls, predicts roll, pitch and yaw with a cordic model of its own
// depends on qte_pkg and quaternion_to_euler_angles_core
`timescale 1ns / 1ps

module quaternion_to_euler_angles_core_tb;

  localparam int unsigned STAGES = qte_pkg::DEF_CORDIC_STAGES;
  localparam int NUM_RANDOM = 1800;
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint Q30_PI = 64'sd3373259426;
  localparam longint Q13_PI = 25736;
  localparam longint Q13_HALF_PI = 12868;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  typedef struct {
    quat_t q;
    bit known;
    euler_t e;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [15:0] quat_x_i;
  logic signed [15:0] quat_y_i;
  logic signed [15:0] quat_z_i;
  logic signed [15:0] quat_w_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [15:0] roll_angle_o;
  logic signed [14:0] pitch_angle_o;
  logic signed [15:0] yaw_angle_o;

  euler_t angles_due[$];
  int mismatches = 0;
  bit stim_done = 0;
  row_t rows[$];

  quaternion_to_euler_angles_core u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .quat_x_i(quat_x_i),
    .quat_y_i(quat_y_i),
    .quat_z_i(quat_z_i),
    .quat_w_i(quat_w_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .roll_angle_o(roll_angle_o),
    .pitch_angle_o(pitch_angle_o),
    .yaw_angle_o(yaw_angle_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arctan_step(int i);
    case (i)
      0: return 843314857;
      1: return 497837829;
      2: return 263043837;
      3: return 133525159;
      4: return 67021687;
      5: return 33543516;
      6: return 16775851;
      7: return 8388437;
      8: return 4194283;
      9: return 2097149;
      default: return 64'sd1 <<< (30 - i);
    endcase
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint ang;
    longint xs;
    longint ys;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? Q30_PI : -Q30_PI;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = shr(x, i);
      ys = shr(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang += arctan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        ang -= arctan_step(i);
      end
    end
    return ang;
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = shr(a + (64'sd1 <<< 16), 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t quat_to_euler(quat_t q);
    longint qx;
    longint qy;
    longint qz;
    longint qw;
    longint sn;
    longint cs;
    euler_t e;
    qx = q.x;
    qy = q.y;
    qz = q.z;
    qw = q.w;
    e.roll = 16'(round_q13(vector_angle(2 * (qw * qx + qy * qz),
                                        Q30_ONE - 2 * (qx * qx + qy * qy)), Q13_PI));
    sn = 2 * (qw * qy - qz * qx);
    if (sn > Q30_ONE) sn = Q30_ONE;
    if (sn < -Q30_ONE) sn = -Q30_ONE;
    cs = floor_sqrt((64'd1 << 60) - longint'(sn * sn));
    e.pitch = 15'(round_q13(vector_angle(sn, cs), Q13_HALF_PI));
    e.yaw = 16'(round_q13(vector_angle(2 * (qw * qz + qx * qy),
                                       Q30_ONE - 2 * (qy * qy + qz * qz)), Q13_PI));
    return e;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic quat_t random_quat();
    quat_t q;
    int r;
    r = $urandom_range(0, 9);
    q = {$urandom, $urandom};
    if (r < 6) begin
      // smaller magnitude: halve each component so it lies within plus or minus one half
      q.x = q.x >>> 1;
      q.y = q.y >>> 1;
      q.z = q.z >>> 1;
      q.w = q.w >>> 1;
    end else if (r == 6) begin
      q.x = 0;
      q.z = 0;
    end
    return q;
  endfunction

  task automatic add_row(quat_t q, bit known, euler_t e);
    row_t rw;
    rw.q = q;
    rw.known = known;
    rw.e = e;
    rows.push_back(rw);
  endtask

  task automatic send_beat(quat_t q, euler_t e);
    in_valid_i <= 1'b1;
    quat_x_i <= q.x;
    quat_y_i <= q.y;
    quat_z_i <= q.z;
    quat_w_i <= q.w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    angles_due.push_back(e);
  endtask

  task automatic idle_beats(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    euler_t z;
    quat_t q;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    quat_x_i = '0;
    quat_y_i = '0;
    quat_z_i = '0;
    quat_w_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    z = '0;
    // identity and all-zero give zero angles
    add_row('{x: 0, y: 0, z: 0, w: 16'sd32767}, 1, z);
    add_row('{x: 0, y: 0, z: 0, w: 0}, 1, z);
    add_row('{x: 0, y: 0, z: 0, w: -16'sd32768}, 1, z);
    // half turn about x: negative x axis, zero y gives pi
    add_row('{x: 16'sd32767, y: 0, z: 0, w: 0}, 1,
            '{roll: 16'sd25736, pitch: 15'sd0, yaw: 16'sd0});
    add_row('{x: 0, y: 0, z: 16'sd32767, w: 0}, 1,
            '{roll: 16'sd0, pitch: 15'sd0, yaw: 16'sd25736});
    add_row('{x: 0, y: 16'sd32767, z: 0, w: 0}, 0, z);
    add_row('{x: 0, y: 16'sd23170, z: 0, w: 16'sd23170}, 0, z);
    add_row('{x: 0, y: -16'sd23170, z: 0, w: 16'sd23170}, 0, z);
    // pitch argument saturates high and low
    add_row('{x: 0, y: 16'sd32767, z: 0, w: 16'sd32767}, 0, z);
    add_row('{x: 0, y: -16'sd32768, z: 0, w: 16'sd32767}, 0, z);
    add_row('{x: -16'sd32768, y: -16'sd32768, z: -16'sd32768, w: -16'sd32768}, 0, z);
    add_row('{x: 16'sd32767, y: 16'sd32767, z: 16'sd32767, w: 16'sd32767}, 0, z);
    add_row('{x: -16'sd32768, y: 16'sd32767, z: -16'sd32768, w: 16'sd32767}, 0, z);
    add_row('{x: 16'sd32767, y: -16'sd32768, z: 16'sd32767, w: -16'sd32768}, 0, z);
    add_row('{x: 16'sd1, y: -16'sd1, z: 16'sd1, w: -16'sd1}, 0, z);
    add_row('{x: 16'sd16384, y: 16'sd16384, z: 16'sd16384, w: 16'sd16384}, 0, z);
    add_row('{x: -16'sd16384, y: 16'sd16384, z: -16'sd16384, w: 16'sd16384}, 0, z);

    foreach (rows[i]) begin
      send_beat(rows[i].q, rows[i].known ? rows[i].e : quat_to_euler(rows[i].q));
      if ($urandom_range(0, 3) == 0) idle_beats(gap_len());
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      q = random_quat();
      send_beat(q, quat_to_euler(q));
      if ((n / 200) % 2 == 1) idle_beats(gap_len());
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = ((($urandom_range(0, 499)) / 100) % 2 == 0) ? gap_len() : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    euler_t got;
    euler_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.roll = roll_angle_o;
      got.pitch = pitch_angle_o;
      got.yaw = yaw_angle_o;
      if (angles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: roll %0d pitch %0d yaw %0d",
                                       got.roll, got.pitch, got.yaw);
      end else begin
        want = angles_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("angle mismatch: exp roll %0d pitch %0d yaw %0d, got %0d %0d %0d",
                     want.roll, want.pitch, want.yaw, got.roll, got.pitch, got.yaw);
        end
      end
    end
  end

  initial begin
    int waited;
    waited = 0;
    wait (stim_done);
    while (angles_due.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4 * (37 + STAGES)) @(posedge clk_i);
    if (mismatches == 0 && angles_due.size() == 0) begin
      $display("quaternion_to_euler_angles_core_tb: clean");
    end else begin
      $display("quaternion_to_euler_angles_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("quaternion_to_euler_angles_core_tb: errors");
    $finish;
  end

endmodule
